// ===== hw/rtl/idle_blank_bouncing_sprite_top_macros.svh =====
// assertion helpers for the sprite saver
`ifndef IDLE_BLANK_BOUNCING_SPRITE_TOP_MACROS_SVH
`define IDLE_BLANK_BOUNCING_SPRITE_TOP_MACROS_SVH

// property checked at every rising clock edge outside reset
`define IBBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at the following clock edge
`define IBBS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ibbs_pkg.sv =====
package ibbs_pkg;

  localparam int unsigned SpriteSize = 80;
  localparam int unsigned FracBits   = 16;

  localparam int unsigned ViewW     = 10;
  localparam int unsigned TimeoutW  = 20;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned ElapsedW  = 12;
  localparam int unsigned PosW      = ViewW + FracBits;
  localparam int unsigned ProdW     = SpeedW + ElapsedW;
  localparam int unsigned DeltaW    = ElapsedW + FracBits;
  localparam int unsigned UpShift   = (FracBits >= 16) ? (FracBits - 16) : 0;
  localparam int unsigned DownShift = (FracBits < 16) ? (16 - FracBits) : 0;
  localparam int unsigned WorkW     = DeltaW + 3;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [ViewW-1:0]    ViewWidthRst  = ViewW'(640);
  localparam logic [ViewW-1:0]    ViewHeightRst = ViewW'(480);
  localparam logic [TimeoutW-1:0] TimeoutRst    = TimeoutW'(60000);
  localparam logic [SpeedW-1:0]   SpeedRst      = SpeedW'(7864);

  typedef enum logic [CfgIdxW-1:0] {
    RegViewWidth  = 8'd0,
    RegViewHeight = 8'd1,
    RegTimeout    = 8'd2,
    RegSpeed      = 8'd3
  } cfg_reg_e;

  typedef logic [PosW-1:0]   pos_t;
  typedef logic [DeltaW-1:0] delta_t;
  typedef logic [ViewW-1:0]  view_t;

  // travel range of the sprite's left or top edge, fixed point
  function automatic pos_t travel_limit(view_t view);
    logic [ViewW:0] span;
    if ({1'b0, view} > (ViewW + 1)'(SpriteSize)) begin
      span = {1'b0, view} - (ViewW + 1)'(SpriteSize);
    end else begin
      span = '0;
    end
    return PosW'(span) << FracBits;
  endfunction

  function automatic pos_t center_pos(view_t view);
    return travel_limit(view) >> 1;
  endfunction

endpackage

// ===== hw/rtl/ibbs_if.sv =====
interface ibbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [ibbs_pkg::ElapsedW-1:0] elapsed_ms;
  logic                          user_input;
  logic                          busy_req;

  modport source (output valid, elapsed_ms, user_input, busy_req, input ready);
  modport sink (input valid, elapsed_ms, user_input, busy_req, output ready);
endinterface

interface ibbs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       saver_active;
  logic [ibbs_pkg::ViewW-1:0] sprite_x;
  logic [ibbs_pkg::ViewW-1:0] sprite_y;

  modport source (output valid, saver_active, sprite_x, sprite_y, input ready);
  modport sink (input valid, saver_active, sprite_x, sprite_y, output ready);
endinterface

interface ibbs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ibbs_pkg::CfgIdxW-1:0]  index;
  logic [ibbs_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/idle_blank_bouncing_sprite_top.sv =====
// idle blanking saver with a bouncing sprite
//
// in_i carries one frame tick per word: elapsed milliseconds, a user input
// flag and a busy flag. out_o returns exactly one word per tick: the saver
// active flag and the integer sprite position. cfg_i writes the four
// registers (view width, view height, idle timeout, speed) by index;
// unknown indexes are dropped, cfg_i.ready is always high. Writing a view
// dimension re-centers the sprite and makes both directions positive.
//
// a tick moves from the input register through the combinational state
// update into the result register that drives out_o. throughput: one tick
// per cycle while out_o does not stall; the idle counter, activation and the
// multiply, reflect and clamp of both axes close in that combinational update.
// when out_o stalls, the result register holds and the input register
// still takes one more tick if it is empty, then in_i.ready drops.
// reset: registers back to defaults, saver inactive, idle count zero,
// sprite centered in a 640 by 480 view, both directions positive.
// configuration must be written only while no tick is in flight; the block does not enforce this.
module idle_blank_bouncing_sprite_top (
  input logic  clk_i,
  input logic  rst_ni,
  ibbs_in_if.sink    in_i,
  ibbs_out_if.source out_o,
  ibbs_cfg_if.sink   cfg_i
);
  import ibbs_pkg::*;

  `include "idle_blank_bouncing_sprite_top_macros.svh"

  logic [ViewW-1:0]    view_w_q, view_w_d;
  logic [ViewW-1:0]    view_h_q, view_h_d;
  logic [TimeoutW-1:0] timeout_q, timeout_d;
  logic [SpeedW-1:0]   speed_q, speed_d;

  logic [TimeoutW-1:0] idle_q, idle_d;
  logic                active_q, active_d;
  pos_t                pos_x_q, pos_x_d;
  pos_t                pos_y_q, pos_y_d;
  logic                neg_x_q, neg_x_d;
  logic                neg_y_q, neg_y_d;

  logic                in_vld_q;
  logic [ElapsedW-1:0] elapsed_q;
  logic                user_q;
  logic                busy_q;

  logic                out_vld_q;
  logic                out_act_q;
  logic [ViewW-1:0]    out_x_q;
  logic [ViewW-1:0]    out_y_q;

  logic                cfg_wr;
  logic                out_free;
  logic                step;
  logic                wake;
  logic [TimeoutW:0]   idle_sum;
  logic [TimeoutW-1:0] idle_sat;
  logic                reached;
  logic                move;
  logic [ProdW-1:0]    prod;
  logic [ProdW+UpShift-1:0] prod_up;
  delta_t              delta;
  pos_t                lim_x;
  pos_t                lim_y;
  pos_t                mv_x;
  pos_t                mv_y;
  logic                mv_neg_x;
  logic                mv_neg_y;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  assign out_free   = !out_vld_q || out_o.ready;
  assign step       = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  // step size rescaled to the position format
  assign prod    = ProdW'(speed_q) * ProdW'(elapsed_q);
  assign prod_up = (ProdW + UpShift)'(prod) << UpShift;
  assign delta   = DeltaW'(prod_up >> DownShift);

  assign lim_x = travel_limit(view_w_q);
  assign lim_y = travel_limit(view_h_q);

  ibbs_axis u_axis_x (
    .pos_i   (pos_x_q),
    .neg_i   (neg_x_q),
    .delta_i (delta),
    .lim_i   (lim_x),
    .pos_o   (mv_x),
    .neg_o   (mv_neg_x)
  );

  ibbs_axis u_axis_y (
    .pos_i   (pos_y_q),
    .neg_i   (neg_y_q),
    .delta_i (delta),
    .lim_i   (lim_y),
    .pos_o   (mv_y),
    .neg_o   (mv_neg_y)
  );

  assign wake     = user_q || busy_q;
  assign idle_sum = (TimeoutW + 1)'(idle_q) + (TimeoutW + 1)'(elapsed_q);
  assign idle_sat = (idle_sum > (TimeoutW + 1)'(timeout_q)) ? timeout_q
                                                            : idle_sum[TimeoutW-1:0];
  assign reached  = (idle_sat >= timeout_q);
  assign move     = !wake && (active_q || reached);

  always_comb begin
    view_w_d  = view_w_q;
    view_h_d  = view_h_q;
    timeout_d = timeout_q;
    speed_d   = speed_q;
    idle_d    = idle_q;
    active_d  = active_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    neg_x_d   = neg_x_q;
    neg_y_d   = neg_y_q;
    if (cfg_wr) begin
      case (cfg_i.index)
        RegViewWidth: begin
          view_w_d = cfg_i.data[ViewW-1:0];
          pos_x_d  = center_pos(cfg_i.data[ViewW-1:0]);
          pos_y_d  = center_pos(view_h_q);
          neg_x_d  = 1'b0;
          neg_y_d  = 1'b0;
        end
        RegViewHeight: begin
          view_h_d = cfg_i.data[ViewW-1:0];
          pos_x_d  = center_pos(view_w_q);
          pos_y_d  = center_pos(cfg_i.data[ViewW-1:0]);
          neg_x_d  = 1'b0;
          neg_y_d  = 1'b0;
        end
        RegTimeout: timeout_d = cfg_i.data[TimeoutW-1:0];
        RegSpeed:   speed_d   = cfg_i.data[SpeedW-1:0];
        default:    ;
      endcase
    end else if (step) begin
      if (wake) begin
        idle_d   = '0;
        active_d = 1'b0;
      end else if (!active_q) begin
        idle_d   = idle_sat;
        active_d = reached;
      end
      if (move) begin
        pos_x_d = mv_x;
        pos_y_d = mv_y;
        neg_x_d = mv_neg_x;
        neg_y_d = mv_neg_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w_q  <= ViewWidthRst;
      view_h_q  <= ViewHeightRst;
      timeout_q <= TimeoutRst;
      speed_q   <= SpeedRst;
      idle_q    <= '0;
      active_q  <= 1'b0;
      pos_x_q   <= center_pos(ViewWidthRst);
      pos_y_q   <= center_pos(ViewHeightRst);
      neg_x_q   <= 1'b0;
      neg_y_q   <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      view_w_q  <= view_w_d;
      view_h_q  <= view_h_d;
      timeout_q <= timeout_d;
      speed_q   <= speed_d;
      idle_q    <= idle_d;
      active_q  <= active_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      neg_x_q   <= neg_x_d;
      neg_y_q   <= neg_y_d;
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      elapsed_q <= in_i.elapsed_ms;
      user_q    <= in_i.user_input;
      busy_q    <= in_i.busy_req;
    end
    if (step) begin
      out_act_q <= active_d;
      out_x_q   <= pos_x_d[PosW-1:FracBits];
      out_y_q   <= pos_y_d[PosW-1:FracBits];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.saver_active = out_act_q;
  assign out_o.sprite_x     = out_x_q;
  assign out_o.sprite_y     = out_y_q;

  `IBBS_ASSERT(a_pos_x_in_range, clk_i, rst_ni, pos_x_q <= lim_x, "sprite x beyond travel")
  `IBBS_ASSERT(a_pos_y_in_range, clk_i, rst_ni, pos_y_q <= lim_y, "sprite y beyond travel")
  `IBBS_ASSERT_NEXT(a_wake_blanks, clk_i, rst_ni, step && !cfg_wr && wake,
    out_o.valid && !out_o.saver_active, "user input left saver active")
  `IBBS_ASSERT_NEXT(a_active_holds, clk_i, rst_ni, !step && !cfg_wr,
    $stable(active_q) && $stable(pos_x_q) && $stable(pos_y_q), "state moved without a tick")
  `IBBS_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, in_vld_q && !out_free,
    in_vld_q && $stable(elapsed_q), "held tick lost in input stage")

endmodule

// ===== hw/rtl/ibbs_axis.sv =====
module ibbs_axis (
  input  ibbs_pkg::pos_t   pos_i,
  input  logic             neg_i,
  input  ibbs_pkg::delta_t delta_i,
  input  ibbs_pkg::pos_t   lim_i,
  output ibbs_pkg::pos_t   pos_o,
  output logic             neg_o
);
  import ibbs_pkg::*;

  logic signed [WorkW-1:0] pos_s;
  logic signed [WorkW-1:0] delta_s;
  logic signed [WorkW-1:0] lim_s;
  logic signed [WorkW-1:0] p0;
  logic signed [WorkW-1:0] p1;
  logic signed [WorkW-1:0] p2;
  logic signed [WorkW-1:0] p3;
  logic                    flip_lo;
  logic                    flip_hi;

  assign pos_s   = signed'(WorkW'(pos_i));
  assign delta_s = signed'(WorkW'(delta_i));
  assign lim_s   = signed'(WorkW'(lim_i));

  always_comb begin
    p0 = neg_i ? (pos_s - delta_s) : (pos_s + delta_s);
    // reflect off the low wall
    flip_lo = (p0 < 0);
    p1 = flip_lo ? -p0 : p0;
    // reflect off the high wall
    flip_hi = (p1 > lim_s);
    p2 = flip_hi ? ((lim_s <<< 1) - p1) : p1;
    if (p2 < 0) begin
      p3 = '0;
    end else if (p2 > lim_s) begin
      p3 = lim_s;
    end else begin
      p3 = p2;
    end
  end

  assign pos_o = PosW'(p3);
  assign neg_o = neg_i ^ flip_lo ^ flip_hi;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import ibbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Limit = 300000;

  typedef struct packed {
    logic  active;
    view_t x;
    view_t y;
  } sprite_frame_t;

  typedef enum logic [1:0] {
    RxFull,
    RxCoin,
    RxSparse,
    RxPeriodic
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ibbs_in_if  in_if ();
  ibbs_out_if out_if ();
  ibbs_cfg_if cfg_if ();

  idle_blank_bouncing_sprite_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // saver state as the block should hold it
  view_t                m_view_w;
  view_t                m_view_h;
  logic [TimeoutW-1:0]  m_timeout;
  logic [SpeedW-1:0]    m_speed;
  logic [TimeoutW-1:0]  m_idle;
  logic                 m_active;
  pos_t                 m_px;
  pos_t                 m_py;
  logic                 m_nx;
  logic                 m_ny;

  sprite_frame_t sprite_frames_q[$];

  int unsigned fails;
  int unsigned cycles;
  int unsigned ticks_sent;
  int unsigned words_checked;
  int unsigned active_words;
  int unsigned regs_written;
  int unsigned burst_left;
  bit          sender_gaps;
  rx_mode_e    rx_mode;
  int unsigned rx_left;

  function automatic longint travel_span(view_t view);
    longint s;
    s = longint'(view) - longint'(SpriteSize);
    if (s < 0) s = 0;
    return s << FracBits;
  endfunction

  task automatic recenter_sprite();
    m_px = pos_t'(travel_span(m_view_w) >> 1);
    m_py = pos_t'(travel_span(m_view_h) >> 1);
    m_nx = 1'b0;
    m_ny = 1'b0;
  endtask

  // one axis: move, reflect at each wall, clamp; returns {direction, position}
  function automatic logic [PosW:0] bounce_axis(pos_t pos, logic neg, longint step,
                                               longint lim);
    longint p;
    p = longint'(pos) + (neg ? -step : step);
    if (p < 0) begin
      p = -p;
      neg = ~neg;
    end
    if (p > lim) begin
      p = lim - (p - lim);
      neg = ~neg;
    end
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    return {neg, p[PosW-1:0]};
  endfunction

  task automatic advance_saver(logic [ElapsedW-1:0] el, logic ui, logic br);
    longint        sum;
    longint        step;
    bit            move;
    sprite_frame_t frame;
    if (ui || br) begin
      m_idle   = '0;
      m_active = 1'b0;
    end else begin
      move = 1'b1;
      if (!m_active) begin
        sum = longint'(m_idle) + longint'(el);
        if (sum > longint'(m_timeout)) sum = longint'(m_timeout);
        m_idle = sum[TimeoutW-1:0];
        if (m_idle >= m_timeout) m_active = 1'b1;
        else move = 1'b0;
      end
      if (move) begin
        step = ((longint'(m_speed) * longint'(el)) << UpShift) >> DownShift;
        {m_nx, m_px} = bounce_axis(m_px, m_nx, step, travel_span(m_view_w));
        {m_ny, m_py} = bounce_axis(m_py, m_ny, step, travel_span(m_view_h));
      end
    end
    frame.active = m_active;
    frame.x      = m_px[FracBits +: ViewW];
    frame.y      = m_py[FracBits +: ViewW];
    sprite_frames_q.push_back(frame);
  endtask

  task automatic apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegViewWidth: begin
        m_view_w = data[ViewW-1:0];
        recenter_sprite();
      end
      RegViewHeight: begin
        m_view_h = data[ViewW-1:0];
        recenter_sprite();
      end
      RegTimeout: begin
        m_timeout = data[TimeoutW-1:0];
      end
      RegSpeed: begin
        m_speed = data[SpeedW-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg_write(idx, data);
    regs_written++;
  endtask

  task automatic release_cfg();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_tick(logic [ElapsedW-1:0] el, logic ui, logic br);
    int unsigned gap;
    in_if.valid      <= 1'b1;
    in_if.elapsed_ms <= el;
    in_if.user_input <= ui;
    in_if.busy_req   <= br;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_saver(el, ui, br);
    ticks_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    while (sprite_frames_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_view();
    view_t v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = view_t'(SpriteSize - 1);
      2: v = view_t'(SpriteSize);
      3: v = view_t'(SpriteSize + 1);
      4: v = '1;
      default: v = view_t'($urandom);
    endcase
    return {(CfgDataW - ViewW)'($urandom), v};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_timeout();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return {(CfgDataW - SpeedW)'($urandom), {SpeedW{1'b1}}};
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [ElapsedW-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      5, 6, 7: return ElapsedW'($urandom_range(0, 63));
      8: return '0;
      9: return '1;
      default: return ElapsedW'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    sprite_frame_t head;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sprite_frames_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual active %0d x %0d y %0d",
                 $time, out_if.saver_active, out_if.sprite_x, out_if.sprite_y);
        fails++;
      end else begin
        head = sprite_frames_q.pop_front();
        check_field("saver_active", 32'(head.active), 32'(out_if.saver_active));
        check_field("sprite_x", 32'(head.x), 32'(out_if.sprite_x));
        check_field("sprite_y", 32'(head.y), 32'(out_if.sprite_y));
        words_checked++;
        if (head.active) active_words++;
      end
    end
  end

  // receiver stall pattern
  initial begin
    out_if.ready <= 1'b0;
    rx_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        RxFull:   out_if.ready <= 1'b1;
        RxCoin:   out_if.ready <= 1'($urandom_range(0, 1));
        RxSparse: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:  out_if.ready <= ((cycles % 8) < 5);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("%0t: run exceeded %0d cycles", $time, Limit);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_wake_inputs();
    send_tick('1, 1'b1, 1'b0);
    send_tick('0, 1'b0, 1'b1);
    send_tick(ElapsedW'(123), 1'b1, 1'b1);
    send_tick('1, 1'b0, 1'b0);
  endtask

  task automatic test_activation_edges();
    wait_results();
    write_reg(RegTimeout, '0);
    write_reg(RegSpeed, CfgDataW'({SpeedW{1'b1}}));
    release_cfg();
    // zero timeout activates on the first quiet tick, then overshoot both walls
    send_tick('0, 1'b0, 1'b0);
    send_tick('1, 1'b0, 1'b0);
    send_tick(ElapsedW'(1), 1'b0, 1'b0);
    send_tick(ElapsedW'(2048), 1'b1, 1'b0);
    wait_results();
    write_reg(RegTimeout, CfgDataW'(50000));
    write_reg(RegSpeed, CfgDataW'(7864));
    release_cfg();
    repeat (3) send_tick('1, 1'b0, 1'b0);
    // timeout lowered below the idle count
    wait_results();
    write_reg(RegTimeout, CfgDataW'(100));
    release_cfg();
    send_tick('0, 1'b0, 1'b0);
    send_tick(ElapsedW'(777), 1'b0, 1'b0);
  endtask

  task automatic test_view_extremes();
    wait_results();
    write_reg(RegViewWidth, '0);
    write_reg(RegViewHeight, CfgDataW'(SpriteSize - 1));
    write_reg(RegTimeout, '0);
    write_reg(RegSpeed, CfgDataW'({SpeedW{1'b1}}));
    release_cfg();
    send_tick('1, 1'b0, 1'b0);
    send_tick(ElapsedW'(17), 1'b0, 1'b0);
    wait_results();
    // upper data bits must be dropped
    write_reg(RegViewWidth, {{(CfgDataW - ViewW){1'b1}}, ViewW'(SpriteSize + 1)});
    write_reg(RegViewHeight, CfgDataW'(SpriteSize));
    write_reg(CfgIdxW'(RegSpeed + 1), '1);
    write_reg('1, '0);
    release_cfg();
    send_tick('1, 1'b0, 1'b0);
    send_tick(ElapsedW'(1), 1'b0, 1'b0);
    wait_results();
    write_reg(RegViewWidth, CfgDataW'({ViewW{1'b1}}));
    write_reg(RegViewHeight, CfgDataW'({ViewW{1'b1}}));
    write_reg(RegSpeed, CfgDataW'(1));
    write_reg(RegTimeout, '1);
    release_cfg();
    send_tick('1, 1'b1, 1'b0);
    send_tick('1, 1'b0, 1'b0);
    send_tick('1, 1'b0, 1'b0);
  endtask

  task automatic test_random_phases();
    int unsigned n_items;
    int unsigned pause_at;
    int unsigned wake_odds;
    logic        ui;
    logic        br;
    for (int ph = 0; ph < 12; ph++) begin
      wait_results();
      if (ph % 3 == 0 || $urandom_range(0, 1)) write_reg(RegViewWidth, pick_view());
      if (ph % 3 == 1 || $urandom_range(0, 1)) write_reg(RegViewHeight, pick_view());
      if (ph % 2 == 0 || $urandom_range(0, 1)) write_reg(RegTimeout, pick_timeout());
      if (ph % 2 == 1 || $urandom_range(0, 1)) write_reg(RegSpeed, pick_speed());
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CfgIdxW'($urandom_range(RegSpeed + 1, 255)), CfgDataW'($urandom));
      end
      release_cfg();
      sender_gaps = (ph % 3 != 1);
      wake_odds   = (ph % 4 == 3) ? 3 : 40;
      n_items     = 60;
      pause_at    = $urandom_range(10, 50);
      for (int k = 0; k < n_items; k++) begin
        // hold off until the pipeline is empty
        if (k == pause_at) wait_results();
        ui = ($urandom_range(1, wake_odds) == 1);
        br = ($urandom_range(1, wake_odds) == 1);
        send_tick(pick_elapsed(), ui, br);
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.elapsed_ms <= '0;
    in_if.user_input <= 1'b0;
    in_if.busy_req   <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    fails         = 0;
    cycles        = 0;
    ticks_sent    = 0;
    words_checked = 0;
    active_words  = 0;
    regs_written  = 0;
    burst_left    = 0;
    sender_gaps   = 1'b1;
    m_view_w  = ViewWidthRst;
    m_view_h  = ViewHeightRst;
    m_timeout = TimeoutRst;
    m_speed   = SpeedRst;
    m_idle    = '0;
    m_active  = 1'b0;
    recenter_sprite();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wake_inputs();
    test_activation_edges();
    test_view_extremes();
    test_random_phases();

    wait_results();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d ticks sent, %0d words checked, %0d with the saver active",
             ticks_sent, words_checked, active_words);
    $display("summary: %0d register writes, small and oversized views included",
             regs_written);
    if (fails == 0 && sprite_frames_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== idle_blank_bouncing_sprite_top.f =====
+incdir+hw/rtl
hw/rtl/ibbs_pkg.sv
hw/rtl/ibbs_if.sv
hw/rtl/ibbs_axis.sv
hw/rtl/idle_blank_bouncing_sprite_top.sv
tb/tb_top.sv
